FILE: design/selective_repeat_receiver_macros.svh
// Assertion macros for the selective-repeat receiver checker.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Implication in the same cycle.
`define SRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the following cycle.
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srr_pkg.sv
// Shared types and constants of the selective-repeat receiver.
package srr_pkg;

    localparam int DRAIN_MAX = 31;
    localparam logic [4:0] WINDOW_RESET = 5'd30;
    localparam int SLOT_W = 34;  // {present, final, timestamp}

    typedef enum logic [1:0] {
        K_DELIVER = 2'd0,
        K_ACK     = 2'd1,
        K_NACK    = 2'd2,
        K_CLOSE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE        = 3'd0,
        E_ACK_LAST    = 3'd1,
        E_NACK        = 3'd2,
        E_ACK_CUR     = 3'd3,
        E_DELIVER_CUR = 3'd4,
        E_DELIVER_NXT = 3'd5,
        E_CLOSE       = 3'd6
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  rd_slot;
        logic  buf_write;
        logic  start_chain;
        logic  rd_next;
        logic  take_next;
        logic  commit;
        logic  close_conn;
        logic  clr_step;
        t_emit emit;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic conn_ok;
        logic decode_ok;
        logic truncated;
        logic in_window;
        logic in_order;
        logic rd_present;
        logic rd_final;
        logic cur_fin;
        logic drain_last;
        logic clr_done;
    } t_status;

endpackage

FILE: design/srr_datapath.sv
// Datapath: request latch, per-connection state, slot memory and result register.
module srr_datapath import srr_pkg::*; #(
    parameter int NUM_CONN = 4,
    parameter int SEQ_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    input  logic [1:0]  i_connection,
    input  logic        i_decode_ok,
    input  logic [7:0]  i_seqnum,
    input  logic        i_truncated,
    input  logic        i_is_data,
    input  logic [9:0]  i_payload_length,
    input  logic [31:0] i_timestamp,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_result_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_out_connection,
    output logic [7:0]  o_out_seqnum,
    output logic [31:0] o_out_timestamp,
    output logic [4:0]  o_advertised_window,
    output logic        o_last
);

    localparam int CW    = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
    localparam int AW    = CW + SEQ_BITS;
    localparam int DEPTH = NUM_CONN << SEQ_BITS;

    logic [4:0]          r_window;
    logic [1:0]          r_conn;
    logic                r_decode_ok;
    logic [SEQ_BITS-1:0] r_seq;
    logic                r_trunc;
    logic                r_fin;
    logic [31:0]         r_ts;

    logic [SEQ_BITS-1:0] r_exp   [NUM_CONN];
    logic [SEQ_BITS-1:0] r_lack  [NUM_CONN];
    logic [31:0]         r_ltime [NUM_CONN];

    logic [SEQ_BITS-1:0] r_cur;
    logic [31:0]         r_curt;
    logic                r_curfin;
    logic [4:0]          r_drained;

    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_clr_last;

    logic [SLOT_W-1:0]   mem [DEPTH];
    logic [SLOT_W-1:0]   r_rd_data;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [1:0]          r_out_conn;
    logic [7:0]          r_out_seq;
    logic [31:0]         r_out_ts;
    logic [4:0]          r_out_win;
    logic                r_out_last;

    logic [CW-1:0]       conn_ix;
    logic [SEQ_BITS-1:0] off;
    logic [SEQ_BITS-1:0] nxt;
    logic [SEQ_BITS-1:0] nxt2;
    logic [SEQ_BITS-1:0] lack_nxt;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SLOT_W-1:0]   wr_data;

    assign conn_ix  = CW'(r_conn);
    assign off      = r_seq - r_exp[conn_ix];
    assign nxt      = r_cur + SEQ_BITS'(1);
    assign nxt2     = r_cur + SEQ_BITS'(2);
    assign lack_nxt = r_lack[conn_ix] + SEQ_BITS'(1);

    // The slot read while draining is the one after the current packet once this cycle ends.
    assign rd_en = i_cmd.rd_slot | i_cmd.rd_next;
    always_comb begin
        if (i_cmd.rd_slot) begin
            rd_addr = {conn_ix, r_seq};
        end else if (i_cmd.take_next) begin
            rd_addr = {conn_ix, nxt2};
        end else begin
            rd_addr = {conn_ix, nxt};
        end
    end

    assign wr_en = i_cmd.clr_step | i_cmd.buf_write | i_cmd.start_chain | i_cmd.take_next;
    always_comb begin
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_addr = r_clr_addr;
        end else if (i_cmd.buf_write) begin
            wr_addr = {conn_ix, r_seq};
            wr_data = {1'b1, r_fin, r_ts};
        end else if (i_cmd.start_chain) begin
            wr_addr = {conn_ix, r_seq};
        end else begin
            wr_addr = {conn_ix, nxt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        o_status.conn_ok    = {5'b0, r_conn} < 7'(NUM_CONN);
        o_status.decode_ok  = r_decode_ok;
        o_status.truncated  = r_trunc;
        o_status.in_window  = 8'(off) < {3'b0, r_window};
        o_status.in_order   = (off == '0);
        o_status.rd_present = r_rd_data[SLOT_W-1];
        o_status.rd_final   = r_rd_data[SLOT_W-2];
        o_status.cur_fin    = r_curfin;
        o_status.drain_last = (r_drained == 5'(DRAIN_MAX - 1));
        o_status.clr_done   = (r_clr_addr == r_clr_last);
    end

    // Request latch and drain registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_conn      <= i_connection;
            r_decode_ok <= i_decode_ok;
            r_seq       <= i_seqnum[SEQ_BITS-1:0];
            r_trunc     <= i_truncated;
            r_fin       <= i_is_data & (i_payload_length == '0);
            r_ts        <= i_timestamp;
        end
        if (i_cmd.start_chain) begin
            r_cur     <= r_seq;
            r_curt    <= r_ts;
            r_curfin  <= r_fin;
            r_drained <= '0;
        end else if (i_cmd.take_next) begin
            r_cur     <= nxt;
            r_curt    <= r_rd_data[31:0];
            r_curfin  <= r_rd_data[SLOT_W-2];
            r_drained <= r_drained + 5'd1;
        end
    end

    // Configuration, per-connection state and clear sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RESET;
            r_clr_addr <= '0;
            r_clr_last <= AW'(DEPTH - 1);
            for (int i = 0; i < NUM_CONN; i++) begin
                r_exp[i]   <= '0;
                r_lack[i]  <= '1;
                r_ltime[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (i_cmd.commit) begin
                r_exp[conn_ix]   <= nxt;
                r_lack[conn_ix]  <= r_cur;
                r_ltime[conn_ix] <= r_curt;
            end else if (i_cmd.close_conn) begin
                r_exp[conn_ix]   <= '0;
                r_lack[conn_ix]  <= '1;
                r_ltime[conn_ix] <= '0;
            end
            if (i_cmd.close_conn) begin
                r_clr_addr <= {conn_ix, {SEQ_BITS{1'b0}}};
                r_clr_last <= {conn_ix, {SEQ_BITS{1'b1}}};
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.emit != E_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_conn <= r_conn;
        r_out_last <= i_cmd.last;
        r_out_win  <= (i_cmd.emit == E_CLOSE) ? 5'd0 : r_window;
        case (i_cmd.emit)
            E_ACK_LAST: begin
                r_kind    <= K_ACK;
                r_out_seq <= 8'(lack_nxt);
                r_out_ts  <= r_ltime[conn_ix];
            end
            E_NACK: begin
                r_kind    <= K_NACK;
                r_out_seq <= 8'(r_seq);
                r_out_ts  <= r_ts;
            end
            E_ACK_CUR: begin
                r_kind    <= K_ACK;
                r_out_seq <= 8'(nxt);
                r_out_ts  <= r_curt;
            end
            E_DELIVER_CUR: begin
                r_kind    <= K_DELIVER;
                r_out_seq <= 8'(r_cur);
                r_out_ts  <= r_curt;
            end
            E_DELIVER_NXT: begin
                r_kind    <= K_DELIVER;
                r_out_seq <= 8'(nxt);
                r_out_ts  <= r_rd_data[31:0];
            end
            E_CLOSE: begin
                r_kind    <= K_CLOSE;
                r_out_seq <= '0;
                r_out_ts  <= '0;
            end
            default: begin
                r_kind    <= K_ACK;
                r_out_seq <= '0;
                r_out_ts  <= '0;
            end
        endcase
    end

    assign o_result_valid      = r_out_valid;
    assign o_kind              = r_kind;
    assign o_out_connection    = r_out_conn;
    assign o_out_seqnum        = r_out_seq;
    assign o_out_timestamp     = r_out_ts;
    assign o_advertised_window = r_out_win;
    assign o_last              = r_out_last;

endmodule

FILE: design/srr_ctrl.sv
// Controller state machine: request classification, drain sequencing and slot clearing.
module srr_ctrl import srr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_BUF   = 8'b0000_1000,
        S_STEP  = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_FINAL = 8'b0100_0000,
        S_CLOSE = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = E_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (!i_status.conn_ok) begin
                    n_state = S_IDLE;
                end else if (!i_status.decode_ok) begin
                    o_cmd.emit = E_ACK_LAST;
                    o_cmd.last = 1'b1;
                end else if (i_status.truncated) begin
                    o_cmd.emit = E_NACK;
                    o_cmd.last = 1'b1;
                end else if (!i_status.in_window) begin
                    n_state = S_IDLE;
                end else if (!i_status.in_order) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state = S_BUF;
                end else begin
                    o_cmd.start_chain = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_BUF: begin
                // Keep the first copy of a duplicate.
                o_cmd.buf_write = !i_status.rd_present;
                o_cmd.emit = E_ACK_LAST;
                o_cmd.last = 1'b1;
                n_state = S_IDLE;
            end
            S_STEP: begin
                if (i_status.cur_fin) begin
                    o_cmd.emit = E_ACK_CUR;
                    n_state = S_CLOSE;
                end else begin
                    o_cmd.emit = E_DELIVER_CUR;
                    o_cmd.rd_next = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.rd_present) begin
                    o_cmd.take_next = 1'b1;
                    if (i_status.rd_final) begin
                        n_state = S_STEP;
                    end else begin
                        o_cmd.emit = E_DELIVER_NXT;
                        if (i_status.drain_last) begin
                            n_state = S_FINAL;
                        end else begin
                            o_cmd.rd_next = 1'b1;
                        end
                    end
                end else begin
                    o_cmd.emit   = E_ACK_CUR;
                    o_cmd.last   = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FINAL: begin
                o_cmd.emit   = E_ACK_CUR;
                o_cmd.last   = 1'b1;
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            S_CLOSE: begin
                o_cmd.emit       = E_CLOSE;
                o_cmd.last       = 1'b1;
                o_cmd.close_conn = 1'b1;
                n_state = S_CLEAR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/selective_repeat_receiver.sv
// Top level of the selective-repeat receiver.
//
//  channel   ports                                  handshake
//  request   i_connection .. i_timestamp            start & !busy
//  result    o_kind .. o_last                       o_result_valid, one cycle
//  config    i_cfg_wr_data (receive window)         i_cfg_wr_en
//
// A request is dropped or answered by a single ack or nack, buffered out of
// order, or, for an in-order packet, drained along with its buffered successors
// (one slot memory read per cycle). Results are registered and appear in the
// cycle after they are formed. A close adds a sweep over the connection's
// 2^SEQ_BITS slots; after reset busy stays high while the whole slot memory of
// NUM_CONN * 2^SEQ_BITS slots is cleared.
module selective_repeat_receiver import srr_pkg::*; #(
    parameter int NUM_CONN = 4,
    parameter int SEQ_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_connection,
    input  logic        i_decode_ok,
    input  logic [7:0]  i_seqnum,
    input  logic        i_truncated,
    input  logic        i_is_data,
    input  logic [9:0]  i_payload_length,
    input  logic [31:0] i_timestamp,
    output logic        o_result_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_out_connection,
    output logic [7:0]  o_out_seqnum,
    output logic [31:0] o_out_timestamp,
    output logic [4:0]  o_advertised_window,
    output logic        o_last
);

    t_cmd    cmd;
    t_status status;

    srr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    srr_datapath #(
        .NUM_CONN (NUM_CONN),
        .SEQ_BITS (SEQ_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_connection        (i_connection),
        .i_decode_ok         (i_decode_ok),
        .i_seqnum            (i_seqnum),
        .i_truncated         (i_truncated),
        .i_is_data           (i_is_data),
        .i_payload_length    (i_payload_length),
        .i_timestamp         (i_timestamp),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_result_valid      (o_result_valid),
        .o_kind              (o_kind),
        .o_out_connection    (o_out_connection),
        .o_out_seqnum        (o_out_seqnum),
        .o_out_timestamp     (o_out_timestamp),
        .o_advertised_window (o_advertised_window),
        .o_last              (o_last)
    );

endmodule

FILE: design/srr_checker.sv
// Port-level checker for the selective-repeat receiver, bound to the top level.
`include "selective_repeat_receiver_macros.svh"

module srr_checker import srr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_seqnum,
    input logic [31:0] o_out_timestamp,
    input logic [4:0]  o_advertised_window,
    input logic        o_last
);

    `SRR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request accepted but not busy")
    `SRR_ASSERT_NOW(a_close_last, i_clk, i_rst_n, o_result_valid && o_kind == K_CLOSE, o_last, "close not last")
    `SRR_ASSERT_NOW(a_close_zero, i_clk, i_rst_n, o_result_valid && o_kind == K_CLOSE, o_out_seqnum == 8'd0 && o_out_timestamp == 32'd0 && o_advertised_window == 5'd0, "close fields not zero")
    `SRR_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, o_result_valid && o_kind == K_CLOSE, busy, "no slot sweep after close")
    `SRR_ASSERT_NOW(a_more_busy, i_clk, i_rst_n, o_result_valid && !o_last, busy, "results pending while idle")

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);
